>>> sv/tetra_face_neighbors_macros.svh
// ----------------------------------------------------------------------------
// tetra_face_neighbors_macros
// Assertion macros shared by the face adjacency block.
// ----------------------------------------------------------------------------
`ifndef TETRA_FACE_NEIGHBORS_MACROS_SVH
`define TETRA_FACE_NEIGHBORS_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TFN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TFN_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TFN_ASSERT_IMP(label, ante, cons, msg)
`define TFN_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and constants of the tetrahedron face adjacency block.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int VTX_W    = 20;
   localparam int ELEM_W   = 10;
   localparam int FACE_W   = 2;
   localparam int STAT_W   = 3;
   localparam int SURF_W   = 13;
   localparam int INNER_W  = 12;
   localparam int CNT_W    = 8;
   localparam int TSL_W    = 4;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic [TSL_W-1:0]  TSL_RESET    = 4'd12;
   localparam logic [CSR_AW-1:0] CSR_TSL_ADDR = 2'd0;

   localparam logic [STAT_W-1:0] ST_NEW    = 3'd0;
   localparam logic [STAT_W-1:0] ST_PAIRED = 3'd1;
   localparam logic [STAT_W-1:0] ST_ODD    = 3'd2;
   localparam logic [STAT_W-1:0] ST_EVEN   = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;
   localparam logic [STAT_W-1:0] ST_OVER   = 3'd5;

   localparam logic [FACE_W-1:0] FIRST_FACE = 2'd0;
   localparam logic [FACE_W-1:0] LAST_FACE  = 2'd3;

   localparam logic [CNT_W-1:0] CNT_SAT  = 8'd255;
   localparam logic [CNT_W-1:0] CNT_BACK = 8'd254;
   localparam logic [CNT_W-1:0] CNT_PAIR = 8'd2;

   typedef struct packed {
      logic                latch_item;
      logic                clear_mesh;
      logic                clr_en;
      logic                load_face;
      logic [FACE_W-1:0]   load_sel;
      logic                probe_rd;
      logic                probe_next;
      logic                commit;
      logic                emit_full;
      logic                emit_over;
      logic [FACE_W-1:0]   face;
      logic                elem_inc;
   } tfn_cmd_type;

   typedef struct packed {
      logic out_busy;
      logic hit;
      logic probe_last;
      logic over_limit;
      logic clear_last;
   } tfn_sts_type;

endpackage

>>> sv/tfn_channels.sv
// ----------------------------------------------------------------------------
// tfn_channels
// Request and response channel interfaces of the face adjacency block.
// ----------------------------------------------------------------------------
interface tfn_req_if import tfn_pkg::*;;
   logic             valid;
   logic             ready;
   logic             start_mesh;
   logic [VTX_W-1:0] vertex_a;
   logic [VTX_W-1:0] vertex_b;
   logic [VTX_W-1:0] vertex_c;
   logic [VTX_W-1:0] vertex_d;

   modport source (output valid, start_mesh, vertex_a, vertex_b, vertex_c, vertex_d,
                   input ready);
   modport sink (input valid, start_mesh, vertex_a, vertex_b, vertex_c, vertex_d,
                 output ready);
endinterface

interface tfn_rsp_if import tfn_pkg::*;;
   logic               valid;
   logic               ready;
   logic [ELEM_W-1:0]  element_index;
   logic [FACE_W-1:0]  face_number;
   logic [STAT_W-1:0]  status;
   logic [ELEM_W-1:0]  partner_element;
   logic [FACE_W-1:0]  partner_face;
   logic [SURF_W-1:0]  surface_faces;
   logic [INNER_W-1:0] inner_faces;
   logic               last_of_item;

   modport source (output valid, element_index, face_number, status, partner_element,
                   partner_face, surface_faces, inner_faces, last_of_item,
                   input ready);
   modport sink (input valid, element_index, face_number, status, partner_element,
                 partner_face, surface_faces, inner_faces, last_of_item,
                 output ready);
endinterface

>>> sv/tfn_ram.sv
// ----------------------------------------------------------------------------
// tfn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tfn_ctrl.sv
// ----------------------------------------------------------------------------
// tfn_ctrl
// Sequencer: clearing sweep, per-face probe loop and result emission.
// ----------------------------------------------------------------------------
module tfn_ctrl import tfn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_start,
   output logic        req_ready,
   input  tfn_sts_type sts,
   output tfn_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_LOAD  = 6'b000100,
      S_PROBE = 6'b001000,
      S_CHECK = 6'b010000,
      S_OVER  = 6'b100000
   } tfn_state_type;

   tfn_state_type     state_ff, state_in;
   logic [FACE_W-1:0] face_ff, face_in;
   logic              pend_ff, pend_in;

   always_comb begin
      state_in  = state_ff;
      face_in   = face_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      req_ready = 1'b0;
      cmd.face  = face_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clear_last) begin
               state_in = pend_ff ? S_LOAD : S_IDLE;
               pend_in  = 1'b0;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               if (req_start) begin
                  cmd.clear_mesh = 1'b1;
                  pend_in        = 1'b1;
                  state_in       = S_CLEAR;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            face_in = FIRST_FACE;
            if (sts.over_limit) begin
               state_in = S_OVER;
            end else begin
               cmd.load_face = 1'b1;
               cmd.load_sel  = FIRST_FACE;
               state_in      = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.probe_rd = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (sts.hit || sts.probe_last) begin
               if (!sts.out_busy) begin
                  cmd.commit    = sts.hit;
                  cmd.emit_full = !sts.hit;
                  if (face_ff == LAST_FACE) begin
                     cmd.elem_inc = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     // next face key loads while this result goes out
                     cmd.load_face = 1'b1;
                     cmd.load_sel  = face_ff + 1'b1;
                     face_in       = face_ff + 1'b1;
                     state_in      = S_PROBE;
                  end
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_PROBE;
            end
         end
         S_OVER: begin
            if (!sts.out_busy) begin
               cmd.emit_over = 1'b1;
               face_in       = face_ff + 1'b1;
               if (face_ff == LAST_FACE) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         face_ff  <= FIRST_FACE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         face_ff  <= face_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

>>> sv/tfn_datapath.sv
// ----------------------------------------------------------------------------
// tfn_datapath
// Face key sort and hash, slot table, counters and the response register.
// ----------------------------------------------------------------------------
module tfn_datapath import tfn_pkg::*; #(
   parameter int TABLE_DEPTH  = 4096,
   parameter int MAX_ELEMENTS = 1024,
   parameter int VERTEX_BITS  = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  tfn_cmd_type        cmd,
   output tfn_sts_type        sts,
   input  logic [TSL_W-1:0]   table_size_log2,
   input  logic [VTX_W-1:0]   vertex_a,
   input  logic [VTX_W-1:0]   vertex_b,
   input  logic [VTX_W-1:0]   vertex_c,
   input  logic [VTX_W-1:0]   vertex_d,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [ELEM_W-1:0]  rsp_element_index,
   output logic [FACE_W-1:0]  rsp_face_number,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [ELEM_W-1:0]  rsp_partner_element,
   output logic [FACE_W-1:0]  rsp_partner_face,
   output logic [SURF_W-1:0]  rsp_surface_faces,
   output logic [INNER_W-1:0] rsp_inner_faces,
   output logic               rsp_last_of_item
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int TOT_W  = ADDR_W + 1;
   localparam int EN_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int KV_W   = VERTEX_BITS;
   localparam int KEY_W  = 3 * KV_W;
   localparam int WORD_W = KEY_W + ELEM_W + FACE_W + CNT_W;
   localparam logic [VTX_W-1:0] VMASK = (VERTEX_BITS >= VTX_W) ? {VTX_W{1'b1}} :
                                        VTX_W'((64'd1 << VERTEX_BITS) - 64'd1);

   logic [VTX_W-1:0]  v_ff [4];
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] probe_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [EN_W-1:0]   elem_ff;
   logic [TOT_W-1:0]  surf_ff, surf_in;
   logic [TOT_W-1:0]  inner_ff, inner_in;
   logic [ADDR_W-1:0] mask;
   logic [TSL_W-1:0]  lg;

   // response register
   logic               rv_ff;
   logic [ELEM_W-1:0]  r_elem_ff;
   logic [FACE_W-1:0]  r_face_ff;
   logic [STAT_W-1:0]  r_stat_ff;
   logic [ELEM_W-1:0]  r_pe_ff;
   logic [FACE_W-1:0]  r_pf_ff;
   logic [SURF_W-1:0]  r_surf_ff;
   logic [INNER_W-1:0] r_inner_ff;

   // table word fields
   logic [WORD_W-1:0] rd_data, wr_data;
   logic [KEY_W-1:0]  rd_key;
   logic [ELEM_W-1:0] rd_elem;
   logic [FACE_W-1:0] rd_face;
   logic [CNT_W-1:0]  rd_cnt, cnt_inc, new_cnt;
   logic [STAT_W-1:0] commit_stat;
   logic [ELEM_W-1:0] elem10;
   logic [31:0]       elem_wide, surf_wide, inner_wide;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;

   // face sort and hash
   logic [VTX_W-1:0]  p0, q0, r0, p1, q1, r1, p2, q2, q3;
   logic [31:0]       hash;

   always_comb begin
      lg = (table_size_log2 == '0) ? TSL_W'(1) : table_size_log2;
      if (32'(lg) >= ADDR_W) begin
         mask = '1;
      end else begin
         mask = ADDR_W'((32'd1 << lg) - 32'd1);
      end
   end

   always_comb begin
      p0 = v_ff[2'(cmd.load_sel + 2'd1)];
      q0 = v_ff[2'(cmd.load_sel + 2'd2)];
      r0 = v_ff[2'(cmd.load_sel + 2'd3)];
      p1 = (p0 < q0) ? q0 : p0;
      q1 = (p0 < q0) ? p0 : q0;
      q2 = (q1 < r0) ? r0 : q1;
      r1 = (q1 < r0) ? q1 : r0;
      p2 = (p1 < q2) ? q2 : p1;
      q3 = (p1 < q2) ? p1 : q2;
      key_in = {KV_W'(p2), KV_W'(q3), KV_W'(r1)};
      hash = 32'(p2) + (32'(q3) << 4) + 32'(q3) + (32'(r1) << 9) + 32'(r1);
      addr_in = cmd.load_face ? (hash[ADDR_W-1:0] & mask) : ((addr_ff + 1'b1) & mask);
   end

   assign {rd_key, rd_elem, rd_face, rd_cnt} = rd_data;
   assign elem_wide = 32'(elem_ff);
   assign elem10    = elem_wide[ELEM_W-1:0];

   always_comb begin
      cnt_inc     = (rd_cnt == CNT_SAT) ? CNT_BACK : rd_cnt + 1'b1;
      surf_in     = surf_ff;
      inner_in    = inner_ff;
      new_cnt     = cnt_inc;
      commit_stat = ST_NEW;
      if (rd_cnt == '0) begin
         new_cnt = CNT_W'(1);
         surf_in = surf_ff + 1'b1;
      end else if (cnt_inc[0]) begin
         commit_stat = ST_ODD;
         surf_in     = surf_ff + 1'b1;
         inner_in    = inner_ff - 1'b1;
      end else begin
         commit_stat = (cnt_inc == CNT_PAIR) ? ST_PAIRED : ST_EVEN;
         surf_in     = surf_ff - 1'b1;
         inner_in    = inner_ff + 1'b1;
      end
      if (!cmd.commit) begin
         surf_in  = surf_ff;
         inner_in = inner_ff;
      end
      surf_wide  = 32'(surf_in);
      inner_wide = 32'(inner_in);
   end

   always_comb begin
      wr_en   = cmd.clr_en || cmd.commit;
      wr_addr = cmd.clr_en ? clr_ff : addr_ff;
      if (cmd.clr_en) begin
         wr_data = '0;
      end else if (rd_cnt == '0) begin
         wr_data = {key_ff, elem10, cmd.face, new_cnt};
      end else begin
         wr_data = {rd_key, rd_elem, rd_face, new_cnt};
      end
   end

   tfn_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.probe_rd),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.out_busy   = rv_ff && !rsp_ready;
      sts.hit        = (rd_cnt == '0) || (rd_key == key_ff);
      sts.probe_last = (probe_ff == mask);
      sts.over_limit = (32'(elem_ff) >= 32'(MAX_ELEMENTS));
      sts.clear_last = (clr_ff == ADDR_W'(TABLE_DEPTH - 1));
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         v_ff[0] <= vertex_a & VMASK;
         v_ff[1] <= vertex_b & VMASK;
         v_ff[2] <= vertex_c & VMASK;
         v_ff[3] <= vertex_d & VMASK;
      end
      if (cmd.load_face) begin
         key_ff <= key_in;
      end
      if (cmd.load_face || cmd.probe_next) begin
         addr_ff <= addr_in;
      end
      if (cmd.load_face) begin
         probe_ff <= '0;
      end else if (cmd.probe_next) begin
         probe_ff <= probe_ff + 1'b1;
      end
      if (cmd.commit || cmd.emit_full || cmd.emit_over) begin
         r_elem_ff  <= cmd.emit_over ? '0 : elem10;
         r_face_ff  <= cmd.face;
         r_stat_ff  <= cmd.commit ? commit_stat : (cmd.emit_full ? ST_FULL : ST_OVER);
         r_pe_ff    <= (cmd.commit && commit_stat == ST_PAIRED) ? rd_elem : '0;
         r_pf_ff    <= (cmd.commit && commit_stat == ST_PAIRED) ? rd_face : '0;
         r_surf_ff  <= (surf_wide > 32'(8191)) ? '1 : surf_wide[SURF_W-1:0];
         r_inner_ff <= (inner_wide > 32'(4095)) ? '1 : inner_wide[INNER_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff    <= 1'b0;
         clr_ff   <= '0;
         elem_ff  <= '0;
         surf_ff  <= '0;
         inner_ff <= '0;
      end else begin
         if (cmd.commit || cmd.emit_full || cmd.emit_over) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
         if (cmd.clr_en) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.clear_mesh) begin
            elem_ff  <= '0;
            surf_ff  <= '0;
            inner_ff <= '0;
         end else begin
            if (cmd.elem_inc) begin
               elem_ff <= elem_ff + 1'b1;
            end
            surf_ff  <= surf_in;
            inner_ff <= inner_in;
         end
      end
   end

   assign rsp_valid           = rv_ff;
   assign rsp_element_index   = r_elem_ff;
   assign rsp_face_number     = r_face_ff;
   assign rsp_status          = r_stat_ff;
   assign rsp_partner_element = r_pe_ff;
   assign rsp_partner_face    = r_pf_ff;
   assign rsp_surface_faces   = r_surf_ff;
   assign rsp_inner_faces     = r_inner_ff;
   assign rsp_last_of_item    = (r_face_ff == LAST_FACE);

endmodule

>>> sv/tetra_face_neighbors.sv
// ----------------------------------------------------------------------------
// tetra_face_neighbors
// Tetrahedron face adjacency through an open-addressed hash of face keys.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  req_chan  in         one tetrahedron: start_mesh and four vertex indices
//  rsp_chan  out        one face result, four per tetrahedron
//  csr_*     in/out     APB-style port, table_size_log2 at address 0
//
//  each probe of a face key is a read of the slot RAM followed by a
//  compare/write step; past the element limit no probe is made and an
//  overflow result goes out for each of the four faces
//  after reset and on each start_mesh a sweep zeroes all TABLE_DEPTH slots
//  of the slot table before requests are taken
//  a stalled response holds the probe loop at its result cycle
// ----------------------------------------------------------------------------
`include "tetra_face_neighbors_macros.svh"

module tetra_face_neighbors import tfn_pkg::*; #(
   parameter int TABLE_DEPTH  = 4096,
   parameter int MAX_ELEMENTS = 1024,
   parameter int VERTEX_BITS  = 20
) (
   input  logic              clock,
   input  logic              reset,
   tfn_req_if.sink           req_chan,
   tfn_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [TSL_W-1:0] tsl_ff;
   tfn_cmd_type      cmd;
   tfn_sts_type      sts;
   logic             req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tsl_ff <= TSL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_TSL_ADDR) begin
         tsl_ff <= csr_pwdata[TSL_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_TSL_ADDR) ? CSR_DW'(tsl_ff) : '0;

   tfn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_start (req_chan.start_mesh),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   tfn_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VERTEX_BITS  (VERTEX_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .table_size_log2     (tsl_ff),
      .vertex_a            (req_chan.vertex_a),
      .vertex_b            (req_chan.vertex_b),
      .vertex_c            (req_chan.vertex_c),
      .vertex_d            (req_chan.vertex_d),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_element_index   (rsp_chan.element_index),
      .rsp_face_number     (rsp_chan.face_number),
      .rsp_status          (rsp_chan.status),
      .rsp_partner_element (rsp_chan.partner_element),
      .rsp_partner_face    (rsp_chan.partner_face),
      .rsp_surface_faces   (rsp_chan.surface_faces),
      .rsp_inner_faces     (rsp_chan.inner_faces),
      .rsp_last_of_item    (rsp_chan.last_of_item)
   );

   // one request in flight at a time
   `TFN_ASSERT_NXT(a_single_req, req_chan.valid && req_chan.ready, !req_chan.ready, "request overlap")
   `TFN_ASSERT_IMP(a_over_elem, rsp_chan.valid && rsp_chan.status == ST_OVER, rsp_chan.element_index == '0, "element index on overflow")
   `TFN_ASSERT_IMP(a_partner_zero, rsp_chan.valid && rsp_chan.status != ST_PAIRED, rsp_chan.partner_element == '0 && rsp_chan.partner_face == '0, "partner without pairing")

endmodule
